[design/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants and types for the stable priority sort block.
// ----------------------------------------------------------------------------
package sps_pkg;

   // Width of the priority field
   localparam int PRIO_W = 2;

   typedef logic [PRIO_W-1:0] prio_type;

   // Priority levels scanned by the drain, highest first
   localparam prio_type PRIO_HIGH = 2'd3;
   localparam prio_type PRIO_ZERO = 2'd0;

endpackage

[design/stable_priority_sort.sv]
// ----------------------------------------------------------------------------
// stable_priority_sort
// Loads task records into a record memory and drains them by descending
// priority, equal priorities in load order.
// ----------------------------------------------------------------------------
// The block takes one record per cycle into a single-port record memory while
// it is loading. The item that carries last_in is stored too (or dropped if
// the memory is full) and starts the drain: the sequencer then reads the
// memory once per priority level, from level 3 down to level 0, walking the
// entries in load order and sending out those of the current level. From the
// last item on, req_stall stays high until the final read has been retired;
// the sequencer issues one memory read per cycle for each of the four levels
// while no matching record waits on rsp_stall, which holds the reads. A set
// that grew beyond CAPACITY records drops the extra ones and flags overflow
// on every result. No clearing pass runs after reset; only written entries
// are read.
module stable_priority_sort #(
   parameter int CAPACITY = 32,
   parameter int ID_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // input items
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ID_WIDTH-1:0]       req_task_id,
   input  logic [sps_pkg::PRIO_W-1:0] req_prio,
   input  logic                      req_done_req,
   input  logic                      req_last_in,
   // result items
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ID_WIDTH-1:0]       rsp_out_id,
   output logic [sps_pkg::PRIO_W-1:0] rsp_out_prio,
   output logic                      rsp_out_done,
   output logic                      rsp_out_last,
   output logic                      rsp_overflow
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int REC_W  = ID_WIDTH + sps_pkg::PRIO_W + 1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // Record memory
   logic [REC_W-1:0] mem [CAPACITY];

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                dropped_ff, dropped_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   sps_pkg::prio_type   scan_prio_ff, scan_prio_in;
   logic [CNT_W-1:0]    emit_cnt_ff, emit_cnt_in;
   logic                rd_valid_ff, rd_valid_in;
   sps_pkg::prio_type   rd_prio_ff;
   logic [REC_W-1:0]    rd_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [REC_W-1:0]    rsp_rec_ff;
   logic                rsp_last_ff;
   logic                rsp_ovf_ff;

   logic                in_acc;
   logic                mem_we;
   logic                rd_issue;
   logic                rd_match;
   logic                out_free;
   logic                emit;
   logic                rd_consumed;
   logic                scan_end;
   logic [CNT_W-1:0]    count_last;
   sps_pkg::prio_type   rd_rec_prio;

   // Decode handshakes and read pipeline
   assign in_acc      = req_valid && !req_stall;
   assign mem_we      = in_acc && (count_ff < CNT_W'(CAPACITY));
   assign rd_rec_prio = rd_data_ff[1 +: sps_pkg::PRIO_W];
   assign rd_match    = rd_rec_prio == rd_prio_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign emit        = rd_valid_ff && rd_match && out_free;
   assign rd_consumed = rd_valid_ff && (!rd_match || out_free);
   assign rd_issue    = (state_ff == ST_SCAN) && (!rd_valid_ff || rd_consumed);
   assign count_last  = count_ff - CNT_W'(1);
   assign scan_end    = (scan_idx_ff == count_last) && (scan_prio_ff == sps_pkg::PRIO_ZERO);

   // Write records during load
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[ADDR_W-1:0]] <= {req_task_id, req_prio, req_done_req};
      end
   end

   // Read records during drain; hold the data until it is consumed
   always_ff @(posedge clock) begin
      if (rd_issue) begin
         rd_data_ff <= mem[scan_idx_ff[ADDR_W-1:0]];
         rd_prio_ff <= scan_prio_ff;
      end
   end

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      scan_idx_in  = scan_idx_ff;
      scan_prio_in = scan_prio_ff;
      emit_cnt_in  = emit_cnt_ff;
      rd_valid_in  = rd_valid_ff;
      rsp_valid_in = rsp_valid_ff;

      // retire the output item
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         emit_cnt_in  = emit_cnt_ff + CNT_W'(1);
      end

      // advance the read stage
      if (rd_consumed) begin
         rd_valid_in = 1'b0;
      end
      if (rd_issue) begin
         rd_valid_in = 1'b1;
      end

      case (state_ff)
         ST_LOAD: begin
            if (in_acc) begin
               if (mem_we) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last_in) begin
                  state_in     = ST_SCAN;
                  scan_idx_in  = '0;
                  scan_prio_in = sps_pkg::PRIO_HIGH;
                  emit_cnt_in  = '0;
               end
            end
         end
         ST_SCAN: begin
            if (rd_issue) begin
               if (scan_end) begin
                  state_in = ST_FLUSH;
               end else if (scan_idx_ff == count_last) begin
                  scan_idx_in  = '0;
                  scan_prio_in = scan_prio_ff - sps_pkg::PRIO_W'(1);
               end else begin
                  scan_idx_in = scan_idx_ff + CNT_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            // drop the set once the final read has left the read stage
            if (!rd_valid_ff || rd_consumed) begin
               state_in   = ST_LOAD;
               count_in   = '0;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         scan_idx_ff  <= '0;
         scan_prio_ff <= sps_pkg::PRIO_HIGH;
         emit_cnt_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         scan_idx_ff  <= scan_idx_in;
         scan_prio_ff <= scan_prio_in;
         emit_cnt_ff  <= emit_cnt_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_rec_ff  <= rd_data_ff;
         rsp_last_ff <= emit_cnt_ff == count_last;
         rsp_ovf_ff  <= dropped_ff;
      end
   end

   // Drive ports
   assign req_stall    = state_ff != ST_LOAD;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_id   = rsp_rec_ff[REC_W-1 -: ID_WIDTH];
   assign rsp_out_prio = rsp_rec_ff[1 +: sps_pkg::PRIO_W];
   assign rsp_out_done = rsp_rec_ff[0];
   assign rsp_out_last = rsp_last_ff;
   assign rsp_overflow = rsp_ovf_ff;

`ifndef NO_ASSERTIONS
   // Fill count never passes the memory depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("record count beyond capacity");

   // No read is in flight while input items are taken
   a_no_read_in_load: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rd_valid_ff)
      else $error("memory read pending during load");

   // A drain never emits more items than were stored
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      emit |-> (emit_cnt_ff < count_ff))
      else $error("more items emitted than stored");

   // The final item of a drain is sent before the next set loads
   a_last_before_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && state_in == ST_LOAD) |-> (emit_cnt_in == count_ff))
      else $error("drain ended with items missing");
`endif

endmodule
